// ===== hw/rtl/priority_aging_scheduler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Priority aging scheduler assertion macros
// Shared concurrent-assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_AGING_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_AGING_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/paw_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority aging scheduler package
// Shared sizes, codes, types and the priority clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package paw_pkg;

    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = $clog2(NUM_TASKS);
    localparam int SLOT_W    = 4;
    localparam int OP_W      = 2;
    localparam int REQ_W     = 7;
    localparam int PRIO_W    = 6;

    typedef logic signed [PRIO_W-1:0] prio_t;
    typedef logic [IDX_W-1:0]         idx_t;

    localparam prio_t PRIO_FLOOR = -6'sd20;
    localparam prio_t PRIO_CEIL  = 6'sd20;
    localparam prio_t AGE_STEP   = 6'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_LEAVE = 2'd1,
        OP_PICK  = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RESP
    } state_e;

    // Scan token handed from one cell to the next.
    typedef struct packed {
        logic  valid;
        logic  have;
        prio_t prio;
        idx_t  idx;
    } scan_t;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic  set;
        logic  leave;
        logic  apply;
        idx_t  win_idx;
        prio_t prio;
    } cell_cmd_t;

    function automatic prio_t clamp_prio(input logic signed [REQ_W-1:0] v);
        prio_t r;
        if (v < REQ_W'(PRIO_FLOOR))
            r = PRIO_FLOOR;
        else if (v > REQ_W'(PRIO_CEIL))
            r = PRIO_CEIL;
        else
            r = prio_t'(v);
        return r;
    endfunction

endpackage

// ===== hw/rtl/priority_aging_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Priority aging scheduler top level
// Task slot table as a chain of cells, with a scan token for pick requests.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on in_valid/in_ready with operation, slot and prio_value.
// Every request returns exactly one result on out_valid/out_ready carrying
// found and chosen_slot.
// A set or leave request is applied at the accepting edge and its result
// (found = 0) is loaded into the output register at that same edge, so it
// shows in the next cycle; such requests can follow each other every cycle
// while the receiver takes each result. A pick request launches a scan
// token into the cell chain. The token steps one cell per cycle through
// every cell; the apply state then ages the other ready slots and restores
// the winner. No new request is taken until the pick's result is loaded
// into the output register.
// If the receiver stalls, the result waits in the output register and the
// next request is held off only until that register is free.
// Reset clears every slot to not ready with both priorities zero, and
// leaves the output empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_aging_scheduler_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [paw_pkg::OP_W-1:0]        operation,
    input  logic [paw_pkg::SLOT_W-1:0]      slot,
    input  logic signed [paw_pkg::REQ_W-1:0] prio_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [paw_pkg::SLOT_W-1:0]      chosen_slot
);
    import paw_pkg::*;

    state_e    state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    logic      found_reg, found_next;
    logic [SLOT_W-1:0] chosen_reg, chosen_next;
    logic      win_have_reg;
    idx_t      win_idx_reg;

    logic      accept;
    logic      accept_pick;
    logic      out_free;
    logic      load_pick;
    cell_cmd_t cmd;
    scan_t     tok [NUM_TASKS+1];
    logic [NUM_TASKS-1:0] sel;
    logic [NUM_TASKS-1:0] tok_valid;

    assign out_free    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign accept_pick = accept && (operation == OP_PICK);

    // The scan token enters the first cell on the cycle a pick is accepted.
    assign tok[0].valid = accept_pick;
    assign tok[0].have  = 1'b0;
    assign tok[0].prio  = '0;
    assign tok[0].idx   = '0;

    // Broadcast command. Set and leave act at the accepting edge; the aging
    // update happens in the apply cycle, and only if some slot was ready.
    assign cmd.set     = accept && (operation == OP_SET);
    assign cmd.leave   = accept && (operation == OP_LEAVE);
    assign cmd.apply   = (state_reg == ST_APPLY) && win_have_reg;
    assign cmd.win_idx = win_idx_reg;
    assign cmd.prio    = clamp_prio(prio_value);

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TASKS; gi++)
        begin : g_cell
            // A slot number beyond the table matches no cell.
            assign sel[gi]       = (32'(slot) == gi);
            assign tok_valid[gi] = tok[gi+1].valid;

            paw_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .sel      (sel[gi]),
                .cell_idx (IDX_W'(gi)),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1])
            );
        end
    endgenerate

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_pick)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok[NUM_TASKS].valid)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = out_free ? ST_IDLE : ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: request handshake and output register loading.
    always_comb
    begin
        in_ready  = 1'b0;
        load_pick = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
            end
            ST_APPLY, ST_RESP:
            begin
                load_pick = out_free;
            end
            default:
            begin
                in_ready  = 1'b0;
                load_pick = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        chosen_next    = chosen_reg;
        if (accept && !accept_pick)
        begin
            out_valid_next = 1'b1;
            found_next     = 1'b0;
            chosen_next    = '0;
        end
        else if (load_pick)
        begin
            out_valid_next = 1'b1;
            found_next     = win_have_reg;
            chosen_next    = win_have_reg ? SLOT_W'(win_idx_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            win_have_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == ST_SCAN) && tok[NUM_TASKS].valid)
                win_have_reg <= tok[NUM_TASKS].have;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        chosen_reg <= chosen_next;
        if ((state_reg == ST_SCAN) && tok[NUM_TASKS].valid)
            win_idx_reg <= tok[NUM_TASKS].idx;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign chosen_slot = chosen_reg;

`include "priority_aging_scheduler_top_defines.svh"

    `PAS_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_valid), "more than one scan token in chain")
    `PAS_ASSERT_NOW(a_token_in_scan, tok[NUM_TASKS].valid, state_reg == ST_SCAN,
        "scan token left the chain outside a scan")
    `PAS_ASSERT_NEXT(a_pick_starts_scan, accept_pick, state_reg == ST_SCAN,
        "accepted pick did not start a scan")
    `PAS_ASSERT_NEXT(a_apply_once, state_reg == ST_APPLY, state_reg != ST_APPLY,
        "aging update applied twice")

endmodule

// ===== hw/rtl/paw_cell.sv =====
// ----------------------------------------------------------------------------
// Priority aging scheduler cell
// One task slot: ready bit, static and dynamic priority, one scan stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module paw_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  paw_pkg::cell_cmd_t cmd,
    input  logic              sel,
    input  paw_pkg::idx_t     cell_idx,
    input  paw_pkg::scan_t    tok_in,
    output paw_pkg::scan_t    tok_out
);
    import paw_pkg::*;

    logic  ready_reg, ready_next;
    prio_t stat_reg, stat_next;
    prio_t dyn_reg, dyn_next;
    logic  tok_valid_reg;
    logic  tok_have_reg, tok_have_next;
    prio_t tok_prio_reg, tok_prio_next;
    idx_t  tok_idx_reg, tok_idx_next;
    logic  take;

    // This slot wins the scan so far when it is ready and strictly better.
    assign take = ready_reg && (!tok_in.have || (dyn_reg < tok_in.prio));

    always_comb
    begin
        tok_have_next = tok_in.have;
        tok_prio_next = tok_in.prio;
        tok_idx_next  = tok_in.idx;
        if (take)
        begin
            tok_have_next = 1'b1;
            tok_prio_next = dyn_reg;
            tok_idx_next  = cell_idx;
        end
    end

    always_comb
    begin
        ready_next = ready_reg;
        stat_next  = stat_reg;
        dyn_next   = dyn_reg;
        if (cmd.set && sel)
        begin
            ready_next = 1'b1;
            stat_next  = cmd.prio;
            dyn_next   = cmd.prio;
        end
        else if (cmd.leave && sel)
        begin
            ready_next = 1'b0;
        end
        else if (cmd.apply)
        begin
            if (cmd.win_idx == cell_idx)
                dyn_next = stat_reg;
            else if (ready_reg)
                dyn_next = (dyn_reg == PRIO_FLOOR) ? PRIO_FLOOR : dyn_reg - AGE_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg     <= 1'b0;
            stat_reg      <= '0;
            dyn_reg       <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            ready_reg     <= ready_next;
            stat_reg      <= stat_next;
            dyn_reg       <= dyn_next;
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_have_reg <= tok_have_next;
        tok_prio_reg <= tok_prio_next;
        tok_idx_reg  <= tok_idx_next;
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.have  = tok_have_reg;
    assign tok_out.prio  = tok_prio_reg;
    assign tok_out.idx   = tok_idx_reg;

endmodule
